/* sv/ipsu_pkg.sv */
package ipsu_pkg;

  localparam int NUM_PARTICLES  = 64;
  localparam int NUM_DIMENSIONS = 16;
  localparam int VEL_DEPTH      = NUM_PARTICLES * NUM_DIMENSIONS;
  localparam int VEL_AW         = $clog2(VEL_DEPTH);

  localparam int PIDX_W    = 6;
  localparam int DIDX_W    = 4;
  localparam int POS_W     = 16;
  localparam int VEL_W     = 18;
  localparam int RAND_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] INERTIA_RST = 16'd11469;
  localparam logic [CFG_W-1:0] PGAIN_RST   = 16'd8192;
  localparam logic [CFG_W-1:0] GGAIN_RST   = 16'd8192;

  localparam int FIFO_DEPTH = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INERTIA_WEIGHT = 2'd0,
    CFG_PERSONAL_GAIN  = 2'd1,
    CFG_GLOBAL_GAIN    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [PIDX_W-1:0] pidx;
    logic [DIDX_W-1:0] didx;
    logic              wr;
    logic [VEL_AW-1:0] addr;
  } tag_t;

  typedef struct packed {
    logic [PIDX_W-1:0]       pidx;
    logic [DIDX_W-1:0]       didx;
    logic signed [POS_W-1:0] pos;
    logic signed [VEL_W-1:0] vel;
    logic                    redrawn;
  } result_t;

endpackage

/* sv/ipsu_if.sv */
interface ipsu_in_if;
  import ipsu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [PIDX_W-1:0]        particle_index;
  logic [DIDX_W-1:0]        dimension_index;
  logic signed [POS_W-1:0]  position;
  logic signed [POS_W-1:0]  personal_best;
  logic signed [POS_W-1:0]  global_best;
  logic signed [POS_W-1:0]  lower_bound;
  logic signed [POS_W-1:0]  upper_bound;
  logic [RAND_W-1:0]        rand_personal;
  logic [RAND_W-1:0]        rand_global;
  logic [RAND_W-1:0]        rand_reset;

  modport source (
    output valid, particle_index, dimension_index, position, personal_best,
           global_best, lower_bound, upper_bound, rand_personal, rand_global,
           rand_reset,
    input  ready
  );

  modport sink (
    input  valid, particle_index, dimension_index, position, personal_best,
           global_best, lower_bound, upper_bound, rand_personal, rand_global,
           rand_reset,
    output ready
  );
endinterface

interface ipsu_out_if;
  import ipsu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [PIDX_W-1:0]        out_particle;
  logic [DIDX_W-1:0]        out_dimension;
  logic signed [POS_W-1:0]  new_position;
  logic signed [VEL_W-1:0]  new_velocity;
  logic                     was_redrawn;

  modport source (
    output valid, out_particle, out_dimension, new_position, new_velocity,
           was_redrawn,
    input  ready
  );

  modport sink (
    input  valid, out_particle, out_dimension, new_position, new_velocity,
           was_redrawn,
    output ready
  );
endinterface

/* sv/ipsu_ram.sv */
module ipsu_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/integer_particle_swarm_update.sv */
// Integer particle-swarm coordinate update.
// in_i carries one coordinate of one particle per word: indexes, position,
// personal and global best, bounds and three random words. out_o returns one
// word per input word, in order: indexes, new position, new velocity and a
// redraw flag. Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i;
// the user must write them only while the block is idle, which the block
// itself does not enforce. An index beyond the list is ignored. One word is
// taken per cycle while in_i.ready is high; a word whose slot matches that of
// the word accepted just before waits until that word has left stage 1, set
// by the read-multiply-write loop through the velocity memory. A word is
// accepted only while fewer than 8 words are in flight or queued in the
// output FIFO, so when the receiver stalls the block keeps taking input
// until 8 words are held, then holds in_i.ready low.
// After reset the velocity memory is cleared one entry per cycle, all 1024
// entries; in_i.ready stays low during that pass, configuration writes
// are taken as usual.
module integer_particle_swarm_update (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ipsu_in_if.sink                         in_i,
  ipsu_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [ipsu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ipsu_pkg::CFG_W-1:0]      cfg_data_i
);
  import ipsu_pkg::*;

  localparam int FPTR_W = $clog2(FIFO_DEPTH);
  localparam int OCC_W  = $clog2(FIFO_DEPTH + 1);
  localparam logic [34:0] INR_HALF  = 35'd1 << 13;
  localparam logic [48:0] PULL_HALF = 49'd1 << 27;
  localparam logic signed [23:0] SUM_MAX = 24'sd131071;
  localparam logic signed [23:0] SUM_MIN = -24'sd131072;

  // configuration
  logic [CFG_W-1:0] w_q, pg_q, gg_q;

  // clearing pass
  logic              clr_q;
  logic [VEL_AW-1:0] clr_cnt_q;

  // accept
  logic              accept, hazard, pop;
  tag_t              in_tag;
  logic [VEL_W-1:0]  ram_rdata;

  // stage 1
  logic                     v1_q;
  tag_t                     tag1_q;
  logic signed [POS_W-1:0]  pos1_q, lo1_q, hi1_q;
  logic                     inv1_q;
  logic signed [16:0]       d1_1_q, d2_1_q;
  logic [16:0]              span1_q;
  logic [RAND_W-1:0]        r1_1_q, r2_1_q, r3_1_q;
  logic signed [VEL_W-1:0]  vold1;
  logic [31:0]              rg1, rg2;
  logic [31:0]              rs;

  // stage 2
  logic                     v2_q;
  tag_t                     tag2_q;
  logic signed [POS_W-1:0]  pos2_q, lo2_q, hi2_q;
  logic                     inv2_q;
  logic signed [VEL_W-1:0]  vold2_q, vold2;
  logic [31:0]              rg1_2_q, rg2_2_q;
  logic [15:0]              m1_2_q, m2_2_q, rs2_q;
  logic                     n1_2_q, n2_2_q;
  logic [VEL_W-1:0]         vmag;
  logic [33:0]              pi;
  logic [47:0]              pp1, pp2;

  // stage 3
  logic                     v3_q;
  tag_t                     tag3_q;
  logic signed [POS_W-1:0]  pos3_q, lo3_q, hi3_q;
  logic                     inv3_q;
  logic [33:0]              pi3_q;
  logic [47:0]              pp1_3_q, pp2_3_q;
  logic                     vn3_q, n1_3_q, n2_3_q;
  logic [15:0]              rs3_q;
  logic [34:0]              si;
  logic [48:0]              sp1, sp2;
  logic signed [21:0]       ti, tp1, tp2;
  logic signed [23:0]       vsum;
  logic signed [VEL_W-1:0]  vnew;

  // stage 4
  logic                     v4_q;
  tag_t                     tag4_q;
  logic signed [POS_W-1:0]  pos4_q, lo4_q, hi4_q;
  logic                     inv4_q;
  logic signed [VEL_W-1:0]  vel4_q;
  logic [15:0]              rs4_q;
  logic signed [18:0]       np19;
  logic                     oob;
  result_t                  res;

  // last memory write, for read-during-write forwarding
  logic                     wb_v_q;
  logic [VEL_AW-1:0]        wb_addr_q;
  logic signed [VEL_W-1:0]  wb_data_q;

  // memory write port
  logic                     ram_we;
  logic [VEL_AW-1:0]        ram_waddr;
  logic [VEL_W-1:0]         ram_wdata;

  // output FIFO
  result_t                  fifo_q [FIFO_DEPTH];
  logic [FPTR_W-1:0]        wr_ptr_q, rd_ptr_q;
  logic [OCC_W-1:0]         occ_q, occ_d;
  logic [OCC_W-1:0]         fcnt_q;

  always_comb begin
    in_tag.pidx = in_i.particle_index;
    in_tag.didx = in_i.dimension_index;
    in_tag.wr   = (32'(in_i.particle_index) < NUM_PARTICLES) &&
                  (32'(in_i.dimension_index) < NUM_DIMENSIONS);
    in_tag.addr = VEL_AW'(32'(in_i.particle_index) * NUM_DIMENSIONS +
                          32'(in_i.dimension_index));
  end

  assign hazard     = v1_q && tag1_q.wr && in_tag.wr && (tag1_q.addr == in_tag.addr);
  assign in_i.ready = !clr_q && (occ_q < OCC_W'(FIFO_DEPTH)) && !hazard;
  assign accept     = in_i.valid && in_i.ready;
  assign pop        = out_o.valid && out_o.ready;

  assign ram_we    = clr_q || (v4_q && tag4_q.wr);
  assign ram_waddr = clr_q ? clr_cnt_q : tag4_q.addr;
  assign ram_wdata = clr_q ? '0 : vel4_q;

  ipsu_ram #(
    .WIDTH (VEL_W),
    .DEPTH (VEL_DEPTH)
  ) u_vel_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_tag.addr),
    .rdata_o (ram_rdata)
  );

  // stage 1: old velocity with forwarding, gain and span products
  always_comb begin
    if (!tag1_q.wr) begin
      vold1 = '0;
    end else if (v4_q && tag4_q.wr && tag4_q.addr == tag1_q.addr) begin
      vold1 = vel4_q;
    end else if (wb_v_q && wb_addr_q == tag1_q.addr) begin
      vold1 = wb_data_q;
    end else begin
      vold1 = $signed(ram_rdata);
    end
    rg1 = 32'(r1_1_q) * 32'(pg_q);
    rg2 = 32'(r2_1_q) * 32'(gg_q);
    rs  = 32'(r3_1_q) * 32'(span1_q);
  end

  // stage 2: inertia and pull products
  always_comb begin
    if (v4_q && tag4_q.wr && tag2_q.wr && tag4_q.addr == tag2_q.addr) begin
      vold2 = vel4_q;
    end else begin
      vold2 = vold2_q;
    end
    vmag = vold2[VEL_W-1] ? VEL_W'(-vold2) : VEL_W'(vold2);
    pi   = 34'(w_q) * 34'(vmag);
    pp1  = 48'(rg1_2_q) * 48'(m1_2_q);
    pp2  = 48'(rg2_2_q) * 48'(m2_2_q);
  end

  // stage 3: round half away from zero, sum, saturate
  always_comb begin
    si  = {1'b0, pi3_q} + INR_HALF;
    sp1 = {1'b0, pp1_3_q} + PULL_HALF;
    sp2 = {1'b0, pp2_3_q} + PULL_HALF;
    ti  = vn3_q ? -$signed({1'b0, si[34:14]})  : $signed({1'b0, si[34:14]});
    tp1 = n1_3_q ? -$signed({1'b0, sp1[48:28]}) : $signed({1'b0, sp1[48:28]});
    tp2 = n2_3_q ? -$signed({1'b0, sp2[48:28]}) : $signed({1'b0, sp2[48:28]});
    vsum = 24'(ti) + 24'(tp1) + 24'(tp2);
    priority if (vsum > SUM_MAX) begin
      vnew = VEL_W'(SUM_MAX);
    end else if (vsum < SUM_MIN) begin
      vnew = VEL_W'(SUM_MIN);
    end else begin
      vnew = VEL_W'(vsum);
    end
  end

  // stage 4: move position, redraw when out of bounds or when the bounds are inverted
  always_comb begin
    np19 = 19'(pos4_q) + 19'(vel4_q);
    oob  = (np19 > 19'(hi4_q)) || (np19 < 19'(lo4_q));
    res.pidx = tag4_q.pidx;
    res.didx = tag4_q.didx;
    res.vel  = vel4_q;
    priority if (inv4_q) begin
      res.pos     = lo4_q;
      res.redrawn = 1'b1;
    end else if (oob) begin
      res.pos     = $signed(POS_W'($unsigned(lo4_q) + rs4_q));
      res.redrawn = 1'b1;
    end else begin
      res.pos     = POS_W'(np19);
      res.redrawn = 1'b0;
    end
  end

  always_comb begin
    occ_d = occ_q;
    if (accept && !pop) begin
      occ_d = occ_q + OCC_W'(1);
    end else if (pop && !accept) begin
      occ_d = occ_q - OCC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q       <= INERTIA_RST;
      pg_q      <= PGAIN_RST;
      gg_q      <= GGAIN_RST;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      wb_v_q    <= 1'b0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      occ_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_INERTIA_WEIGHT: w_q  <= cfg_data_i;
          CFG_PERSONAL_GAIN:  pg_q <= cfg_data_i;
          CFG_GLOBAL_GAIN:    gg_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + VEL_AW'(1);
        if (32'(clr_cnt_q) == VEL_DEPTH - 1) begin
          clr_q <= 1'b0;
        end
      end
      v1_q   <= accept;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      wb_v_q <= v4_q && tag4_q.wr;
      if (v4_q) begin
        wr_ptr_q <= (32'(wr_ptr_q) == FIFO_DEPTH - 1) ? '0 : wr_ptr_q + FPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == FIFO_DEPTH - 1) ? '0 : rd_ptr_q + FPTR_W'(1);
      end
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tag1_q  <= in_tag;
      pos1_q  <= in_i.position;
      lo1_q   <= in_i.lower_bound;
      hi1_q   <= in_i.upper_bound;
      inv1_q  <= in_i.lower_bound > in_i.upper_bound;
      d1_1_q  <= 17'(in_i.personal_best) - 17'(in_i.position);
      d2_1_q  <= 17'(in_i.global_best) - 17'(in_i.position);
      span1_q <= 17'(18'(in_i.upper_bound) - 18'(in_i.lower_bound) + 18'sd1);
      r1_1_q  <= in_i.rand_personal;
      r2_1_q  <= in_i.rand_global;
      r3_1_q  <= in_i.rand_reset;
    end

    tag2_q  <= tag1_q;
    pos2_q  <= pos1_q;
    lo2_q   <= lo1_q;
    hi2_q   <= hi1_q;
    inv2_q  <= inv1_q;
    vold2_q <= vold1;
    rg1_2_q <= rg1;
    rg2_2_q <= rg2;
    m1_2_q  <= d1_1_q[16] ? 16'(-d1_1_q) : 16'(d1_1_q);
    m2_2_q  <= d2_1_q[16] ? 16'(-d2_1_q) : 16'(d2_1_q);
    n1_2_q  <= d1_1_q[16];
    n2_2_q  <= d2_1_q[16];
    rs2_q   <= rs[31:16];

    tag3_q  <= tag2_q;
    pos3_q  <= pos2_q;
    lo3_q   <= lo2_q;
    hi3_q   <= hi2_q;
    inv3_q  <= inv2_q;
    pi3_q   <= pi;
    vn3_q   <= vold2[VEL_W-1];
    pp1_3_q <= pp1;
    pp2_3_q <= pp2;
    n1_3_q  <= n1_2_q;
    n2_3_q  <= n2_2_q;
    rs3_q   <= rs2_q;

    tag4_q  <= tag3_q;
    pos4_q  <= pos3_q;
    lo4_q   <= lo3_q;
    hi4_q   <= hi3_q;
    inv4_q  <= inv3_q;
    vel4_q  <= vnew;
    rs4_q   <= rs3_q;

    wb_addr_q <= tag4_q.addr;
    wb_data_q <= vel4_q;

    if (v4_q) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  assign out_o.valid         = fcnt_q != '0;
  assign out_o.out_particle  = fifo_q[rd_ptr_q].pidx;
  assign out_o.out_dimension = fifo_q[rd_ptr_q].didx;
  assign out_o.new_position  = fifo_q[rd_ptr_q].pos;
  assign out_o.new_velocity  = fifo_q[rd_ptr_q].vel;
  assign out_o.was_redrawn   = fifo_q[rd_ptr_q].redrawn;

  // FIFO holds words only once they leave stage 4; occupancy also counts
  // words still in the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcnt_q <= '0;
    end else begin
      if (v4_q && !pop) begin
        fcnt_q <= fcnt_q + OCC_W'(1);
      end else if (pop && !v4_q) begin
        fcnt_q <= fcnt_q - OCC_W'(1);
      end
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import ipsu_pkg::*;

  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     DRAIN_CYCLES   = 20;
  localparam int     NUM_PHASES     = 10;
  localparam int     PHASE_WORDS    = 50;
  localparam int     MAX_REPORTS    = 10;
  localparam longint VEL_MAX        = (longint'(1) << (VEL_W - 1)) - 1;
  localparam longint VEL_MIN        = -(longint'(1) << (VEL_W - 1));

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [PIDX_W-1:0]       pidx;
    logic [DIDX_W-1:0]       didx;
    logic signed [POS_W-1:0] pos;
    logic signed [POS_W-1:0] pbest;
    logic signed [POS_W-1:0] gbest;
    logic signed [POS_W-1:0] lo;
    logic signed [POS_W-1:0] hi;
    logic [RAND_W-1:0]       rand_p;
    logic [RAND_W-1:0]       rand_g;
    logic [RAND_W-1:0]       rand_r;
  } coord_t;

  typedef enum bit {ROW_WORD, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    coord_t               word;
    bit                   typed;
    result_t              want;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  ipsu_in_if  in_if ();
  ipsu_out_if out_if ();

  integer_particle_swarm_update u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  logic signed [VEL_W-1:0] vel_table [VEL_DEPTH];
  logic [CFG_W-1:0]        inertia_q;
  logic [CFG_W-1:0]        pgain_q;
  logic [CFG_W-1:0]        ggain_q;
  result_t                 coord_result_q [$];
  bit                      cur_typed;
  result_t                 cur_want;
  int                      words_sent;
  int                      words_checked;
  int                      mismatches;
  int                      idle_cycles = 0;
  bit                      no_stall;
  coord_t                  prev_coord;
  dir_row_t                dir_rows [$];

  always #5 clk_i = ~clk_i;

  function automatic longint scale_half_away(input longint unsigned factor,
                                             input longint value, input int shift);
    longint unsigned mag;
    longint unsigned q;
    mag = (value < 0) ? -value : value;
    q   = (factor * mag + (longint'(1) << (shift - 1))) >> shift;
    return (value < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic result_t update_coordinate(input coord_t w);
    int      slot;
    longint  v_old;
    longint  pull_p;
    longint  pull_g;
    longint  v;
    longint  np;
    longint  lo;
    longint  hi;
    result_t r;
    slot   = int'(w.pidx) * NUM_DIMENSIONS + int'(w.didx);
    v_old  = vel_table[slot];
    pull_p = scale_half_away(longint'(w.rand_p) * longint'(pgain_q),
                             longint'(w.pbest) - longint'(w.pos), 28);
    pull_g = scale_half_away(longint'(w.rand_g) * longint'(ggain_q),
                             longint'(w.gbest) - longint'(w.pos), 28);
    v = scale_half_away(longint'(inertia_q), v_old, 14) + pull_p + pull_g;
    if (v > VEL_MAX) v = VEL_MAX;
    if (v < VEL_MIN) v = VEL_MIN;
    vel_table[slot] = v[VEL_W-1:0];
    lo = w.lo;
    hi = w.hi;
    np = longint'(w.pos) + v;
    r.redrawn = 1'b0;
    if (lo > hi) begin
      np = lo;
      r.redrawn = 1'b1;
    end else if (np > hi || np < lo) begin
      np = lo + ((longint'(w.rand_r) * (hi - lo + 1)) >> 16);
      r.redrawn = 1'b1;
    end
    r.pidx = w.pidx;
    r.didx = w.didx;
    r.pos  = np[POS_W-1:0];
    r.vel  = v[VEL_W-1:0];
    return r;
  endfunction

  function automatic dir_row_t mk_word(input int p, d, pos, pb, gb, lo, hi, rp, rg, rr);
    dir_row_t r;
    r.kind         = ROW_WORD;
    r.reg_idx      = '0;
    r.reg_val      = '0;
    r.typed        = 1'b0;
    r.want         = '0;
    r.word.pidx    = PIDX_W'(p);
    r.word.didx    = DIDX_W'(d);
    r.word.pos     = POS_W'(pos);
    r.word.pbest   = POS_W'(pb);
    r.word.gbest   = POS_W'(gb);
    r.word.lo      = POS_W'(lo);
    r.word.hi      = POS_W'(hi);
    r.word.rand_p  = RAND_W'(rp);
    r.word.rand_g  = RAND_W'(rg);
    r.word.rand_r  = RAND_W'(rr);
    return r;
  endfunction

  function automatic dir_row_t with_result(input dir_row_t r, input int np, v,
                                           input bit rd);
    r.typed        = 1'b1;
    r.want.pidx    = r.word.pidx;
    r.want.didx    = r.word.didx;
    r.want.pos     = POS_W'(np);
    r.want.vel     = VEL_W'(v);
    r.want.redrawn = rd;
    return r;
  endfunction

  function automatic dir_row_t mk_cfg(input logic [CFG_IDX_W-1:0] idx,
                                      input int val);
    dir_row_t r;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = CFG_W'(val);
    r.word    = '0;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic int clip16(input int x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic logic [CFG_W-1:0] pick_cfg(input logic [CFG_W-1:0] dflt);
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return dflt;
      default: return CFG_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_INERTIA_WEIGHT: inertia_q = val;
      CFG_PERSONAL_GAIN:  pgain_q   = val;
      CFG_GLOBAL_GAIN:    ggain_q   = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_word(input coord_t w, input bit typed, input result_t want);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.particle_index  <= w.pidx;
    in_if.dimension_index <= w.didx;
    in_if.position        <= w.pos;
    in_if.personal_best   <= w.pbest;
    in_if.global_best     <= w.gbest;
    in_if.lower_bound     <= w.lo;
    in_if.upper_bound     <= w.hi;
    in_if.rand_personal   <= w.rand_p;
    in_if.rand_global     <= w.rand_g;
    in_if.rand_reset      <= w.rand_r;
    cur_typed             <= typed;
    cur_want              <= want;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    words_sent++;
  endtask

  // wait until every accepted word has come back
  task automatic settle();
    in_if.valid <= 1'b0;
    while (words_checked < words_sent) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : predict_word
    coord_t  w;
    result_t r;
    if (rst_ni && in_if.valid && in_if.ready) begin
      w.pidx   = in_if.particle_index;
      w.didx   = in_if.dimension_index;
      w.pos    = in_if.position;
      w.pbest  = in_if.personal_best;
      w.gbest  = in_if.global_best;
      w.lo     = in_if.lower_bound;
      w.hi     = in_if.upper_bound;
      w.rand_p = in_if.rand_personal;
      w.rand_g = in_if.rand_global;
      w.rand_r = in_if.rand_reset;
      r = update_coordinate(w);
      coord_result_q.push_back(cur_typed ? cur_want : r);
    end
  end

  always @(posedge clk_i) begin : check_result
    result_t got;
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.pidx    = out_if.out_particle;
      got.didx    = out_if.out_dimension;
      got.pos     = out_if.new_position;
      got.vel     = out_if.new_velocity;
      got.redrawn = out_if.was_redrawn;
      words_checked++;
      if (coord_result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected word: p=%0d d=%0d pos=%0d vel=%0d redrawn=%0b",
                   got.pidx, got.didx, got.pos, got.vel, got.redrawn);
      end else begin
        want = coord_result_q.pop_front();
        if (got.pidx !== want.pidx || got.didx !== want.didx || got.pos !== want.pos ||
            got.vel !== want.vel || got.redrawn !== want.redrawn) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $write("word %0d: exp p=%0d d=%0d pos=%0d vel=%0d redrawn=%0b, ",
                   words_checked, want.pidx, want.didx, want.pos, want.vel,
                   want.redrawn);
            $display("got p=%0d d=%0d pos=%0d vel=%0d redrawn=%0b",
                     got.pidx, got.didx, got.pos, got.vel, got.redrawn);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : drain_results
    int gap;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = no_stall ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  initial begin : stimulus
    dir_row_t row;
    coord_t   c;
    bit       in_cfg;
    int       kind;
    int       lo_i;
    int       hi_i;
    int       pos_i;
    int       mid;
    int       half;

    clk_i                 = 1'b0;
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = '0;
    cfg_data_i            = '0;
    in_if.valid           = 1'b0;
    in_if.particle_index  = '0;
    in_if.dimension_index = '0;
    in_if.position        = '0;
    in_if.personal_best   = '0;
    in_if.global_best     = '0;
    in_if.lower_bound     = '0;
    in_if.upper_bound     = '0;
    in_if.rand_personal   = '0;
    in_if.rand_global     = '0;
    in_if.rand_reset      = '0;
    cur_typed             = 1'b0;
    cur_want              = '0;
    words_sent            = 0;
    words_checked         = 0;
    mismatches            = 0;
    no_stall              = 1'b0;
    prev_coord            = '0;
    inertia_q             = INERTIA_RST;
    pgain_q               = PGAIN_RST;
    ggain_q               = GGAIN_RST;
    foreach (vel_table[i]) vel_table[i] = '0;

    // reset settings, fresh table
    dir_rows.push_back(with_result(
      mk_word(0, 0, 0, 0, 0, -100, 100, 'h1234, 'h8000, 0), 0, 0, 1'b0));
    // inverted bounds
    dir_rows.push_back(with_result(
      mk_word(1, 1, 3, 3, 3, 5, -5, 'hFFFF, 'hFFFF, 'hFFFF), 5, 0, 1'b1));
    // positive saturation, redraw to lower bound
    dir_rows.push_back(with_result(
      mk_word(2, 2, -32768, 32767, 32767, -32768, 32767, 'hFFFF, 'hFFFF, 0),
      -32768, 131071, 1'b1));
    dir_rows.push_back(mk_word(2, 2, 0, 0, 0, -32768, 32767, 0, 0, 'h8000));
    // negative saturation, redraw to upper bound
    dir_rows.push_back(with_result(
      mk_word(63, 15, 32767, -32768, -32768, -32768, 32767, 'hFFFF, 'hFFFF, 'hFFFF),
      32767, -131072, 1'b1));
    dir_rows.push_back(mk_word(63, 15, 1000, -1000, 2000, -32768, 32767,
                               'hAAAA, 'h5555, 'h0F0F));
    dir_rows.push_back(with_result(
      mk_word(4, 4, 7, 7, 7, 7, 7, 'h8000, 'h8000, 'h1234), 7, 0, 1'b0));
    dir_rows.push_back(mk_cfg(CFG_INERTIA_WEIGHT, 'hFFFF));
    dir_rows.push_back(mk_cfg(CFG_PERSONAL_GAIN, 0));
    dir_rows.push_back(mk_cfg(CFG_GLOBAL_GAIN, 0));
    dir_rows.push_back(mk_word(2, 2, 0, 0, 0, -32768, 32767, 0, 0, 'h0001));
    dir_rows.push_back(mk_word(2, 2, 0, 0, 0, -32768, 32767, 0, 0, 'hFFFE));
    dir_rows.push_back(mk_word(2, 2, 0, 0, 0, -32768, 32767, 0, 0, 'h7FFF));
    dir_rows.push_back(mk_cfg(CFG_INERTIA_WEIGHT, 0));
    dir_rows.push_back(mk_cfg(CFG_PERSONAL_GAIN, 'hFFFF));
    dir_rows.push_back(mk_cfg(CFG_GLOBAL_GAIN, 'hFFFF));
    dir_rows.push_back(mk_cfg(CFG_SPARE, 'hFFFF));
    dir_rows.push_back(mk_word(2, 2, 100, -100, 300, -200, 200, 'h8000, 'h0001, 'h4321));
    dir_rows.push_back(mk_word(3, 5, -32768, 32767, -32768, -32768, 32767,
                               'h0001, 'h0000, 'h7FFF));
    // exact halves in the pull and inertia rounding
    dir_rows.push_back(mk_cfg(CFG_INERTIA_WEIGHT, 16384));
    dir_rows.push_back(mk_cfg(CFG_PERSONAL_GAIN, 4096));
    dir_rows.push_back(mk_cfg(CFG_GLOBAL_GAIN, 4096));
    dir_rows.push_back(mk_word(10, 3, 0, 1, -3, -10, 10, 'h8000, 'h8000, 0));
    dir_rows.push_back(mk_word(10, 3, 0, 0, 0, -10, 10, 0, 0, 0));
    dir_rows.push_back(mk_cfg(CFG_INERTIA_WEIGHT, 8192));
    dir_rows.push_back(mk_word(10, 3, 0, 0, 0, -10, 10, 0, 0, 0));
    dir_rows.push_back(mk_word(10, 3, 0, 0, 0, -10, 10, 0, 0, 0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    in_cfg = 1'b0;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        if (!in_cfg) settle();
        in_cfg = 1'b1;
        cfg_write(row.reg_idx, row.reg_val);
      end else begin
        if (in_cfg) cfg_we_i <= 1'b0;
        in_cfg = 1'b0;
        send_word(row.word, 1'b0 | row.typed, row.want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      cfg_write(CFG_INERTIA_WEIGHT, pick_cfg(INERTIA_RST));
      cfg_write(CFG_PERSONAL_GAIN, pick_cfg(PGAIN_RST));
      cfg_write(CFG_GLOBAL_GAIN, pick_cfg(GGAIN_RST));
      if ($urandom_range(0, 3) == 0) cfg_write(CFG_SPARE, CFG_W'($urandom_range(0, 65535)));
      cfg_we_i <= 1'b0;
      no_stall = ($urandom_range(0, 3) == 0);
      repeat (PHASE_WORDS) begin
        c.rand_p = RAND_W'($urandom_range(0, 65535));
        c.rand_g = RAND_W'($urandom_range(0, 65535));
        c.rand_r = RAND_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 7) == 0) c.rand_p = '1;
        if ($urandom_range(0, 7) == 0) c.rand_g = '0;
        // revisit a few slots often so velocities build up
        if ($urandom_range(0, 7) == 0) begin
          c.pidx = prev_coord.pidx;
          c.didx = prev_coord.didx;
        end else if ($urandom_range(0, 1) == 1) begin
          c.pidx = PIDX_W'($urandom_range(0, 3));
          c.didx = DIDX_W'($urandom_range(0, 3));
        end else begin
          c.pidx = PIDX_W'($urandom_range(0, NUM_PARTICLES - 1));
          c.didx = DIDX_W'($urandom_range(0, NUM_DIMENSIONS - 1));
        end
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          lo_i = int'($urandom_range(0, 65534)) - 32767;
          hi_i = int'($urandom_range(0, lo_i + 32767)) - 32768;
        end else if (kind == 1) begin
          lo_i = -32768;
          hi_i = 32767;
        end else if (kind == 2) begin
          lo_i = int'($urandom_range(0, 65535)) - 32768;
          hi_i = lo_i;
        end else begin
          mid  = int'($urandom_range(0, 65535)) - 32768;
          half = $urandom_range(0, 4000);
          lo_i = clip16(mid - half);
          hi_i = clip16(mid + half);
        end
        if (lo_i <= hi_i && $urandom_range(0, 3) != 0)
          pos_i = lo_i + int'($urandom_range(0, hi_i - lo_i));
        else
          pos_i = int'($urandom_range(0, 65535)) - 32768;
        c.lo  = POS_W'(lo_i);
        c.hi  = POS_W'(hi_i);
        c.pos = POS_W'(pos_i);
        if ($urandom_range(0, 3) == 0)
          c.pbest = POS_W'($urandom_range(0, 65535));
        else
          c.pbest = POS_W'(clip16(pos_i + int'($urandom_range(0, 4000)) - 2000));
        if ($urandom_range(0, 3) == 0)
          c.gbest = POS_W'($urandom_range(0, 65535));
        else
          c.gbest = POS_W'(clip16(pos_i + int'($urandom_range(0, 4000)) - 2000));
        prev_coord = c;
        send_word(c, 1'b0, '0);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && coord_result_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
